@@ rtl/core/pnsel_pkg.sv @@
// Shared constants, codes and the control type of the periodic nearest-neighbor selector.
`default_nettype none

package pnsel_pkg;

    // Default sizes of the design.
    localparam int MAX_POINTS_DEF    = 64;
    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int COORD_BITS_DEF    = 20;

    // Widths of the fixed-size configuration registers.
    localparam int NEIGHBOR_COUNT_W = 4;
    localparam int POINT_COUNT_W    = 7;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_SIZE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT    = 2'd2;

    // Reset values of the configuration registers.
    localparam int BOX_SIZE_RESET = 102400;
    localparam logic [NEIGHBOR_COUNT_W-1:0] NEIGHBOR_COUNT_RESET = 4'd1;
    localparam logic [POINT_COUNT_W-1:0]    POINT_COUNT_RESET    = 7'd20;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Control of the sorting chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } pnsel_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/pnsel_req_if.sv @@
// Request channel: point loads and queries.
`default_nettype none

interface pnsel_req_if #(
    parameter int IDX_W   = 6,
    parameter int COORD_W = 20
);
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    modport source (output valid, output req_type, output point_index,
                    output pos_x, output pos_y, input ready);
    modport sink   (input valid, input req_type, input point_index,
                    input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pnsel_res_if.sv @@
// Result channel: one neighbor index per transaction.
`default_nettype none

interface pnsel_res_if #(
    parameter int IDX_W = 6
);
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] neighbor_index;
    logic             last_neighbor;

    modport source (output valid, output neighbor_index, output last_neighbor,
                    input ready);
    modport sink   (input valid, input neighbor_index, input last_neighbor,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/pnsel_dist.sv @@
// Four-stage pipeline for the periodic squared distance of one point to the reference.
`default_nettype none

module pnsel_dist #(
    parameter int COORD_BITS = 20,
    parameter int IDX_W      = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [IDX_W-1:0]        in_idx,
    input  logic [COORD_BITS-1:0]   pt_x,
    input  logic [COORD_BITS-1:0]   pt_y,
    input  logic [COORD_BITS-1:0]   ref_x,
    input  logic [COORD_BITS-1:0]   ref_y,
    input  logic [COORD_BITS-1:0]   box_size,
    output logic                    cand_valid,
    output logic [IDX_W-1:0]        cand_idx,
    output logic [2*COORD_BITS:0]   cand_dist
);
    import pnsel_pkg::*;

    localparam int DW = COORD_BITS + 2;

    // Smallest magnitude of d, d - L and d + L; never above |d|.
    function automatic logic [COORD_BITS-1:0] axis_min(
        input logic signed [DW-1:0] d,
        input logic [COORD_BITS-1:0] len
    );
        logic signed [DW-1:0] l;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic [DW-1:0] m0;
        logic [DW-1:0] m1;
        logic [DW-1:0] m2;
        logic [DW-1:0] m;
        l  = signed'({2'b00, len});
        a  = d - l;
        b  = d + l;
        m0 = d[DW-1] ? DW'(-d) : DW'(d);
        m1 = a[DW-1] ? DW'(-a) : DW'(a);
        m2 = b[DW-1] ? DW'(-b) : DW'(b);
        m  = m0;
        if (m1 < m)
        begin
            m = m1;
        end
        if (m2 < m)
        begin
            m = m2;
        end
        return m[COORD_BITS-1:0];
    endfunction

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [IDX_W-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic signed [DW-1:0]    s1_dx_reg, s1_dy_reg;
    logic [COORD_BITS-1:0]   s2_mx_reg, s2_my_reg;
    logic [2*COORD_BITS-1:0] s3_sx_reg, s3_sy_reg;
    logic [2*COORD_BITS:0]   s4_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= in_idx;
        s1_dx_reg   <= signed'({2'b00, pt_x}) - signed'({2'b00, ref_x});
        s1_dy_reg   <= signed'({2'b00, pt_y}) - signed'({2'b00, ref_y});
        s2_idx_reg  <= s1_idx_reg;
        s2_mx_reg   <= axis_min(s1_dx_reg, box_size);
        s2_my_reg   <= axis_min(s1_dy_reg, box_size);
        s3_idx_reg  <= s2_idx_reg;
        s3_sx_reg   <= s2_mx_reg * s2_mx_reg;
        s3_sy_reg   <= s2_my_reg * s2_my_reg;
        s4_idx_reg  <= s3_idx_reg;
        s4_dist_reg <= {1'b0, s3_sx_reg} + {1'b0, s3_sy_reg};
    end

    assign cand_valid = s4_valid_reg;
    assign cand_idx   = s4_idx_reg;
    assign cand_dist  = s4_dist_reg;

endmodule

`default_nettype wire

@@ rtl/core/pnsel_cell.sv @@
// One cell of the sorting chain: keeps the nearer candidate, passes the other on.
`default_nettype none

module pnsel_cell #(
    parameter int DIST_W = 41,
    parameter int IDX_W  = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pnsel_pkg::pnsel_ctl_t    ctl,
    input  logic                     in_valid,
    input  logic [DIST_W-1:0]        in_dist,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic                     right_valid,
    input  logic [DIST_W-1:0]        right_dist,
    input  logic [IDX_W-1:0]         right_idx,
    output logic                     hold_valid,
    output logic [DIST_W-1:0]        hold_dist,
    output logic [IDX_W-1:0]         hold_idx,
    output logic                     pass_valid,
    output logic [DIST_W-1:0]        pass_dist,
    output logic [IDX_W-1:0]         pass_idx
);
    import pnsel_pkg::*;

    logic              hold_valid_reg, hold_valid_next;
    logic [DIST_W-1:0] hold_dist_reg, hold_dist_next;
    logic [IDX_W-1:0]  hold_idx_reg, hold_idx_next;
    logic              pass_valid_reg, pass_valid_next;
    logic [DIST_W-1:0] pass_dist_reg, pass_dist_next;
    logic [IDX_W-1:0]  pass_idx_reg, pass_idx_next;
    logic              take;

    // Cells further down see candidates out of index order, so equal distances
    // are ordered by index here.
    assign take = !hold_valid_reg || (in_dist < hold_dist_reg)
               || ((in_dist == hold_dist_reg) && (in_idx < hold_idx_reg));

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_dist_next  = hold_dist_reg;
        hold_idx_next   = hold_idx_reg;
        pass_valid_next = 1'b0;
        pass_dist_next  = pass_dist_reg;
        pass_idx_next   = pass_idx_reg;
        if (ctl.clear)
        begin
            hold_valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            hold_valid_next = right_valid;
            hold_dist_next  = right_dist;
            hold_idx_next   = right_idx;
        end
        else if (in_valid)
        begin
            if (take)
            begin
                hold_valid_next = 1'b1;
                hold_dist_next  = in_dist;
                hold_idx_next   = in_idx;
                pass_valid_next = hold_valid_reg;
                pass_dist_next  = hold_dist_reg;
                pass_idx_next   = hold_idx_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_dist_next  = in_dist;
                pass_idx_next   = in_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_dist_reg <= hold_dist_next;
        hold_idx_reg  <= hold_idx_next;
        pass_dist_reg <= pass_dist_next;
        pass_idx_reg  <= pass_idx_next;
    end

    assign hold_valid = hold_valid_reg;
    assign hold_dist  = hold_dist_reg;
    assign hold_idx   = hold_idx_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_dist  = pass_dist_reg;
    assign pass_idx   = pass_idx_reg;

endmodule

`default_nettype wire

@@ rtl/core/pnsel_chain.sv @@
// Row of sorting cells; cell 0 holds the nearest candidate seen so far.
`default_nettype none

module pnsel_chain #(
    parameter int CELLS  = 8,
    parameter int DIST_W = 41,
    parameter int IDX_W  = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pnsel_pkg::pnsel_ctl_t ctl,
    input  logic                  cand_valid,
    input  logic [DIST_W-1:0]     cand_dist,
    input  logic [IDX_W-1:0]      cand_idx,
    output logic [IDX_W-1:0]      head_idx
);
    import pnsel_pkg::*;

    logic              link_valid [CELLS+1];
    logic [DIST_W-1:0] link_dist  [CELLS+1];
    logic [IDX_W-1:0]  link_idx   [CELLS+1];
    logic              hold_valid [CELLS+1];
    logic [DIST_W-1:0] hold_dist  [CELLS+1];
    logic [IDX_W-1:0]  hold_idx   [CELLS+1];

    assign link_valid[0] = cand_valid;
    assign link_dist[0]  = cand_dist;
    assign link_idx[0]   = cand_idx;

    // An empty slot beyond the last cell feeds the shift toward the head.
    assign hold_valid[CELLS] = 1'b0;
    assign hold_dist[CELLS]  = '0;
    assign hold_idx[CELLS]   = '0;

    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        pnsel_cell #(
            .DIST_W (DIST_W),
            .IDX_W  (IDX_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .in_valid    (link_valid[j]),
            .in_dist     (link_dist[j]),
            .in_idx      (link_idx[j]),
            .right_valid (hold_valid[j+1]),
            .right_dist  (hold_dist[j+1]),
            .right_idx   (hold_idx[j+1]),
            .hold_valid  (hold_valid[j]),
            .hold_dist   (hold_dist[j]),
            .hold_idx    (hold_idx[j]),
            .pass_valid  (link_valid[j+1]),
            .pass_dist   (link_dist[j+1]),
            .pass_idx    (link_idx[j+1])
        );
    end

    assign head_idx = hold_idx[0];

endmodule

`default_nettype wire

@@ rtl/core/periodic_q_nearest_select.sv @@
// Top level of the periodic nearest-neighbor selector.
//
// Channels: req carries loads (req_type 0: store pos_x/pos_y at point_index)
// and queries (req_type 1: reference point point_index). res carries one
// transaction per reported neighbor, nearest first, last_neighbor on the final
// one. cfg_write/cfg_index/cfg_data write the registers; there is no read-back.
// A load is taken and ready stays high. A query walks the point memory one
// entry per cycle through a single read port: a scan over the points in use,
// the first step of which also latches the reference point, then a drain while
// the distance pipeline and the sorting chain settle, then one cycle per
// neighbor while res is ready. A query with a neighbor count of zero still
// runs through the scan; one with fewer than two points in use or a reference
// out of range is taken and dropped at once.
// A stalled receiver holds the output register and with it the sorting chain;
// the next request is taken as soon as the last result sits in that register.
// Reset clears control state and restores the configuration defaults; the
// point memory holds no defined contents until loaded.
`default_nettype none

module periodic_q_nearest_select #(
    parameter int MAX_POINTS    = pnsel_pkg::MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = pnsel_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = pnsel_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pnsel_req_if.sink                          req,
    pnsel_res_if.source                        res,
    input  logic                               cfg_write,
    input  logic [pnsel_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]              cfg_data
);
    import pnsel_pkg::*;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = (IDX_W + 1 > POINT_COUNT_W) ? IDX_W + 1 : POINT_COUNT_W;
    localparam int DIST_W    = 2 * COORD_BITS + 1;
    localparam int DRAIN_LEN = MAX_NEIGHBORS + 8;
    localparam int DRAIN_W   = $clog2(DRAIN_LEN);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_REF   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COORD_BITS-1:0]   box_size_reg;
    logic [NEIGHBOR_COUNT_W-1:0] neighbor_count_reg;
    logic [POINT_COUNT_W-1:0]    point_count_reg;

    logic [2*COORD_BITS-1:0] point_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_write;

    logic [IDX_W-1:0]        ref_idx_reg, ref_idx_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [COORD_BITS-1:0]   ref_x_reg, ref_y_reg;
    logic                    tag_valid_reg, tag_valid_next;
    logic [IDX_W-1:0]        tag_idx_reg;
    logic [DRAIN_W-1:0]      drain_cnt_reg, drain_cnt_next;
    logic [CNT_W-1:0]        emit_k_reg, emit_k_next;

    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_idx_reg, out_idx_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic                    issue;
    logic                    scan_last;
    logic                    emit_last;
    logic                    out_free;
    logic                    query_ok;
    logic [CNT_W-1:0]        pc_ext, count_eff, nc_clamp, q_eff;
    pnsel_ctl_t              chain_ctl;

    logic                    cand_valid;
    logic [IDX_W-1:0]        cand_idx;
    logic [DIST_W-1:0]       cand_dist;
    logic [IDX_W-1:0]        head_idx;

    // Effective point count and number of neighbors to report.
    always_comb
    begin
        pc_ext    = CNT_W'(point_count_reg);
        count_eff = (pc_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pc_ext;
        nc_clamp  = (CNT_W'(neighbor_count_reg) > CNT_W'(MAX_NEIGHBORS))
                  ? CNT_W'(MAX_NEIGHBORS) : CNT_W'(neighbor_count_reg);
        q_eff     = (nc_clamp > count_eff - CNT_W'(1)) ? count_eff - CNT_W'(1) : nc_clamp;
    end

    assign accept    = req.valid && req.ready;
    assign query_ok  = (count_eff >= CNT_W'(2)) && (CNT_W'(req.point_index) < count_eff);
    assign scan_last = (CNT_W'(scan_idx_reg) == count_eff - CNT_W'(1));
    assign emit_last = (emit_k_reg + CNT_W'(1) == q_eff);
    assign out_free  = !out_valid_reg || res.ready;
    assign issue     = (state_reg == S_REF) || (state_reg == S_SCAN);
    assign mem_write = accept && (req.req_type == REQ_LOAD)
                    && (CNT_W'(req.point_index) < CNT_W'(MAX_POINTS));
    assign rd_addr   = (state_reg == S_IDLE) ? req.point_index : scan_idx_reg;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ref_idx_next    = ref_idx_reg;
        scan_idx_next   = scan_idx_reg;
        drain_cnt_next  = drain_cnt_reg;
        emit_k_next     = emit_k_reg;
        tag_valid_next  = issue && (scan_idx_reg != ref_idx_reg);
        out_valid_next  = out_valid_reg && !res.ready;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        chain_ctl.clear = 1'b0;
        chain_ctl.shift = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.req_type == REQ_QUERY) && query_ok)
                begin
                    ref_idx_next    = req.point_index;
                    scan_idx_next   = '0;
                    chain_ctl.clear = 1'b1;
                    state_next      = S_REF;
                end
            end
            S_REF, S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_last)
                begin
                    drain_cnt_next = DRAIN_W'(DRAIN_LEN - 1);
                    state_next     = S_DRAIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg - DRAIN_W'(1);
                if (drain_cnt_reg == '0)
                begin
                    emit_k_next = '0;
                    state_next  = (q_eff == '0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = head_idx;
                    out_last_next   = emit_last;
                    chain_ctl.shift = 1'b1;
                    emit_k_next     = emit_k_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            tag_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            box_size_reg       <= COORD_BITS'(BOX_SIZE_RESET);
            neighbor_count_reg <= NEIGHBOR_COUNT_RESET;
            point_count_reg    <= POINT_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= tag_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BOX_SIZE:       box_size_reg       <= cfg_data;
                    REG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg_data[NEIGHBOR_COUNT_W-1:0];
                    REG_POINT_COUNT:    point_count_reg    <= cfg_data[POINT_COUNT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ref_idx_reg   <= ref_idx_next;
        scan_idx_reg  <= scan_idx_next;
        drain_cnt_reg <= drain_cnt_next;
        emit_k_reg    <= emit_k_next;
        tag_idx_reg   <= scan_idx_reg;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        // The reference point is read first; its data is here while in S_REF.
        if (state_reg == S_REF)
        begin
            ref_x_reg <= rd_data_reg[2*COORD_BITS-1:COORD_BITS];
            ref_y_reg <= rd_data_reg[COORD_BITS-1:0];
        end
    end

    // Point memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            point_mem[req.point_index] <= {req.pos_x, req.pos_y};
        end
        rd_data_reg <= point_mem[rd_addr];
    end

    pnsel_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (tag_valid_reg),
        .in_idx     (tag_idx_reg),
        .pt_x       (rd_data_reg[2*COORD_BITS-1:COORD_BITS]),
        .pt_y       (rd_data_reg[COORD_BITS-1:0]),
        .ref_x      (ref_x_reg),
        .ref_y      (ref_y_reg),
        .box_size   (box_size_reg),
        .cand_valid (cand_valid),
        .cand_idx   (cand_idx),
        .cand_dist  (cand_dist)
    );

    pnsel_chain #(
        .CELLS  (MAX_NEIGHBORS),
        .DIST_W (DIST_W),
        .IDX_W  (IDX_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (chain_ctl),
        .cand_valid (cand_valid),
        .cand_dist  (cand_dist),
        .cand_idx   (cand_idx),
        .head_idx   (head_idx)
    );

    assign res.valid          = out_valid_reg;
    assign res.neighbor_index = out_idx_reg;
    assign res.last_neighbor  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/pnsel_checker.sv @@
// Port-level checks of the selector and their binding to the top level.
`default_nettype none

module pnsel_checker #(
    parameter int IDX_W = 6
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_type,
    input logic             res_valid,
    input logic             res_ready,
    input logic [IDX_W-1:0] neighbor_index,
    input logic             last_neighbor
);
    import pnsel_pkg::*;

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(neighbor_index) && $stable(last_neighbor))
        else $error("result payload changed while stalled");

    // A load never blocks the request channel.
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_LOAD) |=> req_ready)
        else $error("request channel blocked after a load");

    // The request channel only closes after a query transaction.
    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid) && $past(req_type == REQ_QUERY))
        else $error("request channel closed without a query");

endmodule

bind periodic_q_nearest_select pnsel_checker #(
    .IDX_W ($clog2(MAX_POINTS))
) u_pnsel_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_type       (req.req_type),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .neighbor_index (res.neighbor_index),
    .last_neighbor  (res.last_neighbor)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench of the periodic nearest-neighbor selector.
`timescale 1ns / 100ps

module tb;
    import pnsel_pkg::*;

    localparam int NPTS       = 64;
    localparam int NNEIGH     = 8;
    localparam int CW         = 20;
    localparam int SETTLE     = 150;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AFTER = 40;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 41;

    typedef struct {
        logic          req_type;
        logic [5:0]    point_index;
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
    } request_t;

    typedef struct {
        logic [5:0] neighbor_index;
        logic       last_neighbor;
    } neighbor_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    pnsel_req_if #(.IDX_W(6), .COORD_W(CW)) req_ch ();
    pnsel_res_if #(.IDX_W(6)) res_ch ();

    periodic_q_nearest_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's configuration and point memory.
    logic [CW-1:0] box_len;
    logic [3:0]    want_neighbors;
    logic [6:0]    points_used;
    logic [CW-1:0] pt_x [NPTS];
    logic [CW-1:0] pt_y [NPTS];

    request_t  request_q [$];
    neighbor_t neighbor_q [$];

    int  errors;
    int  n_requests;
    int  n_queries;
    int  n_results;
    int  n_settings;
    int  hold_left;
    bit  hold_done;
    bit  calm;
    bit  req_taken;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

    function automatic longint unsigned axis_square(logic [CW-1:0] a, logic [CW-1:0] b,
                                                    logic [CW-1:0] len);
        longint d;
        longint m;
        longint m1;
        longint m2;
        d  = longint'(a) - longint'(b);
        m  = (d < 0) ? -d : d;
        m1 = (d - longint'(len) < 0) ? longint'(len) - d : d - longint'(len);
        m2 = (d + longint'(len) < 0) ? -(d + longint'(len)) : d + longint'(len);
        if (m1 < m)
            m = m1;
        if (m2 < m)
            m = m2;
        return longint'(m * m);
    endfunction

    function automatic void predict_neighbors(request_t r);
        int              eff;
        int              q;
        int              best;
        bit              found;
        longint unsigned sq_dist [NPTS];
        bit              taken [NPTS];
        neighbor_t       n;
        if (r.req_type == REQ_LOAD)
        begin
            pt_x[r.point_index] = r.pos_x;
            pt_y[r.point_index] = r.pos_y;
            return;
        end
        eff = (points_used > NPTS) ? NPTS : int'(points_used);
        if (eff < 2 || int'(r.point_index) >= eff)
            return;
        q = (want_neighbors > NNEIGH) ? NNEIGH : int'(want_neighbors);
        if (q > eff - 1)
            q = eff - 1;
        for (int i = 0; i < eff; i++)
        begin
            taken[i]   = 1'b0;
            sq_dist[i] = axis_square(pt_x[i], pt_x[r.point_index], box_len) +
                         axis_square(pt_y[i], pt_y[r.point_index], box_len);
        end
        taken[r.point_index] = 1'b1;
        for (int k = 0; k < q; k++)
        begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < eff; i++)
            begin
                if (!taken[i] && (!found || sq_dist[i] < sq_dist[best]))
                begin
                    found = 1'b1;
                    best  = i;
                end
            end
            taken[best] = 1'b1;
            n.neighbor_index = best[5:0];
            n.last_neighbor  = (k == q - 1);
            neighbor_q.push_back(n);
        end
    endfunction

    // Request driver: at the falling edge after acceptance, a new request or a gap.
    always @(posedge clk)
    begin
        request_t r;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            r.req_type    = req_ch.req_type;
            r.point_index = req_ch.point_index;
            r.pos_x       = req_ch.pos_x;
            r.pos_y       = req_ch.pos_y;
            predict_neighbors(r);
            n_requests++;
            if (r.req_type == REQ_QUERY)
                n_queries++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            req_taken = 1'b0;
            if (request_q.size() != 0 && (calm || $urandom_range(99) >= 7))
            begin
                r = request_q.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= r.req_type;
                req_ch.point_index <= r.point_index;
                req_ch.pos_x       <= r.pos_x;
                req_ch.pos_y       <= r.pos_y;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result sink: random stalls, plus one long hold-off that lets the block back up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        neighbor_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            n_results++;
            if (neighbor_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result index %0d last %0b", $realtime,
                             res_ch.neighbor_index, res_ch.last_neighbor);
            end
            else
            begin
                e = neighbor_q.pop_front();
                if (res_ch.neighbor_index !== e.neighbor_index ||
                    res_ch.last_neighbor !== e.last_neighbor)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result mismatch: expected index %0d last %0b, got %0d %0b",
                                 $realtime, e.neighbor_index, e.last_neighbor,
                                 res_ch.neighbor_index, res_ch.last_neighbor);
                end
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        logic [CW-1:0] c;
        case ($urandom_range(4))
            0: c = CW'($urandom_range(3) << 8);
            1: c = (box_len != 0) ? CW'($urandom_range(int'(box_len) - 1))
                                  : CW'($urandom_range(4095));
            2: c = ($urandom_range(1) != 0) ? {CW{1'b1}} : '0;
            default: c = CW'($urandom());
        endcase
        return c;
    endfunction

    function automatic request_t load_of(int idx, logic [CW-1:0] x, logic [CW-1:0] y);
        request_t r;
        r.req_type    = REQ_LOAD;
        r.point_index = idx[5:0];
        r.pos_x       = x;
        r.pos_y       = y;
        return r;
    endfunction

    // A query carries random coordinates, which the block must ignore.
    function automatic request_t query_of(int idx);
        request_t r;
        r.req_type    = REQ_QUERY;
        r.point_index = idx[5:0];
        r.pos_x       = CW'($urandom());
        r.pos_y       = CW'($urandom());
        return r;
    endfunction

    // Waits until all requests are taken and all results are in, then lets the
    // block finish any query that reports nothing.
    task automatic settle();
        while (request_q.size() != 0 || req_ch.valid || neighbor_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BOX_SIZE:       box_len = val;
            REG_NEIGHBOR_COUNT: want_neighbors = val[3:0];
            REG_POINT_COUNT:    points_used = val[6:0];
            default: ;
        endcase
    endtask

    task automatic new_setting(logic [CW-1:0] box, logic [3:0] nq, logic [6:0] np);
        settle();
        write_reg(REG_BOX_SIZE, box);
        write_reg(REG_NEIGHBOR_COUNT, CW'(nq));
        write_reg(REG_POINT_COUNT, CW'(np));
        @(negedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        int eff;
        logic [CW-1:0] box;
        logic [3:0]    nq;
        logic [6:0]    np;

        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.point_index = '0;
        req_ch.pos_x       = '0;
        req_ch.pos_y       = '0;
        res_ch.ready       = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        box_len            = CW'(BOX_SIZE_RESET);
        want_neighbors     = NEIGHBOR_COUNT_RESET;
        points_used        = POINT_COUNT_RESET;
        errors     = 0;
        n_requests = 0;
        n_queries  = 0;
        n_results  = 0;
        n_settings = 1;
        hold_left  = 0;
        hold_done  = 1'b0;
        calm       = 1'b0;
        req_taken  = 1'b0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every point is loaded before the first query, since a query scans every point in use.
        request_q.push_back(load_of(0, '0, '0));
        request_q.push_back(load_of(1, {CW{1'b1}}, {CW{1'b1}}));
        for (int i = 2; i < NPTS; i++)
            request_q.push_back(load_of(i, rand_coord(), rand_coord()));

        // Directed part under the reset configuration.
        request_q.push_back(load_of(2, {CW{1'b1}}, '0));
        request_q.push_back(load_of(3, '0, {CW{1'b1}}));
        request_q.push_back(load_of(4, CW'(100), CW'(100)));
        request_q.push_back(load_of(5, CW'(100), CW'(100)));
        request_q.push_back(load_of(6, CW'(BOX_SIZE_RESET + 50), '0));
        request_q.push_back(query_of(4));
        request_q.push_back(query_of(0));
        request_q.push_back(query_of(19));
        request_q.push_back(query_of(20));
        request_q.push_back(query_of(63));

        // Zero box gives plain distance; neighbor count above the maximum is clamped.
        new_setting('0, 4'd15, 7'd64);
        request_q.push_back(query_of(4));
        request_q.push_back(query_of(63));
        request_q.push_back(query_of(2));

        // Largest box; point count above the maximum is clamped.
        new_setting({CW{1'b1}}, 4'd8, 7'd127);
        request_q.push_back(query_of(0));
        request_q.push_back(query_of(3));

        // Too few points, then a neighbor count of zero.
        new_setting(CW'(256), 4'd3, 7'd1);
        request_q.push_back(query_of(0));
        new_setting(CW'(256), 4'd3, 7'd0);
        request_q.push_back(query_of(0));
        new_setting(CW'(256), 4'd0, 7'd20);
        request_q.push_back(query_of(1));

        // Two points with the smallest nonzero box: the count clamps to one neighbor.
        new_setting(CW'(1), 4'd8, 7'd2);
        request_q.push_back(query_of(0));
        request_q.push_back(query_of(1));

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(4))
                0: box = CW'($urandom_range(8192, 256));
                1: box = {CW{1'b1}};
                2: box = CW'($urandom_range(255, 0));
                default: box = CW'($urandom_range((1 << CW) - 1, 1));
            endcase
            nq = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
            np = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 2));
            new_setting(box, nq, np);
            calm = (p == 2);
            eff = (np > NPTS) ? NPTS : int'(np);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 35)
                    request_q.push_back(load_of($urandom_range(NPTS - 1),
                                                rand_coord(), rand_coord()));
                else if (eff >= 1 && $urandom_range(99) < 90)
                    request_q.push_back(query_of($urandom_range(eff - 1)));
                else
                    request_q.push_back(query_of($urandom_range(NPTS - 1)));
            end
        end

        settle();
        calm = 1'b0;
        if (neighbor_q.size() != 0)
        begin
            errors += neighbor_q.size();
            $display("%0d expected results never arrived", neighbor_q.size());
        end
        $display("tb: %0d requests, %0d of them queries, across %0d register settings",
                 n_requests, n_queries, n_settings);
        $display("tb: %0d neighbor results checked, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
